@@ hw/rtl/lzsr_pkg.sv @@
`default_nettype none
package lzsr_pkg;

    localparam int MAX_LEN    = 1024;
    localparam int VALUE_BITS = 16;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 16;
    localparam int SUM_W      = VALUE_BITS + $clog2(MAX_LEN + 1);
    localparam int POS_W      = $clog2(MAX_LEN + 1);
    localparam int LEN_W      = 11;

    typedef enum logic {
        ST_RUN,
        ST_DRAIN
    } state_t;

    typedef struct packed {
        logic                    valid;
        logic                    active;
        logic                    last;
        logic                    over;
        logic signed [SUM_W-1:0] sum;
        logic [POS_W-1:0]        pos;
        logic                    found;
        logic [LEN_W-1:0]        len;
    } query_t;

    typedef struct packed {
        logic                    en;
        logic                    zero_en;
        logic [POS_W-1:0]        idx;
        logic signed [SUM_W-1:0] sum;
    } wr_t;

endpackage
`default_nettype wire

@@ hw/rtl/longest_zero_sum_run.sv @@
// Longest zero-sum run finder. Array elements stream in on the slave side, one transaction
// per element, with tlast on the final one; one result transaction (run length and a
// too-long flag) follows each array. Within an array an element is taken every cycle:
// the head forms the prefix sum and writes it into the cell of its position, while the
// query for that sum walks a chain of MAX_LEN match cells, one cell per cycle. After the
// last element the input stalls until its query has left the chain and the output
// register is free to take the result; the result then waits in the output register and
// the next array may begin before it is taken.
// Elements beyond MAX_LEN are ignored and raise the too-long flag.
`default_nettype none
module longest_zero_sum_run
    import lzsr_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,   // value
    input  wire logic                  s_tlast,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_DATA_W-1:0]      m_tdata,   // length, zero padded
    output logic [0:0]                 m_tuser    // too_long
);

    query_t q [MAX_LEN:0];
    wr_t    wr;
    logic   done;

    lzsr_head u_head (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .done     (done),
        .q_out    (q[0]),
        .wr       (wr)
    );

    for (genvar i = 0; i < MAX_LEN; i++) begin : g_cell
        lzsr_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .idx     (POS_W'(i)),
            .wr      (wr),
            .q_in    (q[i]),
            .q_out   (q[i+1])
        );
    end

    lzsr_tail u_tail (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_in     (q[MAX_LEN]),
        .done     (done),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
`default_nettype wire

@@ hw/rtl/lzsr_head.sv @@
`default_nettype none
module lzsr_head
    import lzsr_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [IN_DATA_W-1:0] s_tdata,
    input  wire logic                 s_tlast,
    input  wire logic                 done,
    output query_t                    q_out,
    output wr_t                       wr
);

    state_t                  state_reg, state_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic [POS_W-1:0]        pos_reg, pos_next;
    logic                    over_reg, over_next;

    logic                    accept;
    logic                    live;
    logic signed [SUM_W-1:0] vext;
    logic signed [SUM_W-1:0] new_sum;
    logic [POS_W-1:0]        new_pos;

    assign vext    = SUM_W'($signed(s_tdata[VALUE_BITS-1:0]));
    assign new_sum = sum_reg + vext;
    assign new_pos = pos_reg + POS_W'(1);
    assign live    = pos_reg < POS_W'(MAX_LEN);
    assign accept  = s_tvalid && s_tready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_RUN: begin
                if (accept && s_tlast) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (done) begin
                    state_next = ST_RUN;
                end
            end
            default: state_next = ST_RUN;
        endcase
    end

    always_comb begin
        s_tready = (state_reg == ST_RUN);

        q_out.valid  = accept;
        q_out.active = live;
        q_out.last   = s_tlast;
        q_out.over   = over_reg || !live;
        q_out.sum    = new_sum;
        q_out.pos    = new_pos;
        q_out.found  = 1'b0;
        q_out.len    = '0;

        wr.en      = accept && live && (new_pos < POS_W'(MAX_LEN));
        wr.zero_en = (pos_reg == '0);
        wr.idx     = new_pos;
        wr.sum     = new_sum;
    end

    always_comb begin
        sum_next  = sum_reg;
        pos_next  = pos_reg;
        over_next = over_reg;
        priority if (accept && s_tlast) begin
            sum_next  = '0;
            pos_next  = '0;
            over_next = 1'b0;
        end else if (accept && live) begin
            sum_next = new_sum;
            pos_next = new_pos;
        end else if (accept) begin
            over_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_RUN;
            sum_reg   <= '0;
            pos_reg   <= '0;
            over_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            sum_reg   <= sum_next;
            pos_reg   <= pos_next;
            over_reg  <= over_next;
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/lzsr_cell.sv @@
`default_nettype none
module lzsr_cell
    import lzsr_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic [POS_W-1:0] idx,
    input  wire wr_t              wr,
    input  wire query_t           q_in,
    output query_t                q_out
);

    logic signed [SUM_W-1:0] store_reg;
    logic                    valid_reg;
    query_t                  q_reg;
    logic                    hit;

    // prefix sum of this cell's position
    always_ff @(posedge aclk) begin
        if (wr.zero_en && (idx == '0)) begin
            store_reg <= '0;
        end else if (wr.en && (wr.idx == idx)) begin
            store_reg <= wr.sum;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= q_in.valid;
        end
    end

    always_ff @(posedge aclk) begin
        q_reg <= q_in;
    end

    // first match along the chain is the earliest position
    assign hit = valid_reg && q_reg.active && !q_reg.found && (idx < q_reg.pos)
                 && (store_reg == q_reg.sum);

    always_comb begin
        q_out       = q_reg;
        q_out.valid = valid_reg;
        if (hit) begin
            q_out.found = 1'b1;
            q_out.len   = LEN_W'(q_reg.pos - idx);
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/lzsr_tail.sv @@
`default_nettype none
module lzsr_tail
    import lzsr_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire query_t                q_in,
    output logic                       done,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_DATA_W-1:0]      m_tdata,
    output logic [0:0]                 m_tuser
);

    logic [LEN_W-1:0] best_reg, best_next;
    logic             pend_valid_reg, pend_valid_next;
    logic [LEN_W-1:0] pend_len_reg;
    logic             pend_over_reg;
    logic             out_valid_reg, out_valid_next;
    logic [LEN_W-1:0] out_len_reg;
    logic             out_over_reg;
    logic [LEN_W-1:0] cand;
    logic [LEN_W-1:0] best_max;
    logic             out_free;
    logic             take_last;

    assign cand      = q_in.found ? q_in.len : '0;
    assign best_max  = (cand > best_reg) ? cand : best_reg;
    assign out_free  = !out_valid_reg || m_tready;
    assign done      = pend_valid_reg && out_free;
    assign take_last = q_in.valid && q_in.last;

    always_comb begin
        best_next = best_reg;
        if (take_last) begin
            best_next = '0;
        end else if (q_in.valid) begin
            best_next = best_max;
        end
    end

    always_comb begin
        pend_valid_next = pend_valid_reg;
        out_valid_next  = out_valid_reg;
        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        if (done) begin
            pend_valid_next = 1'b0;
            out_valid_next  = 1'b1;
        end
        if (take_last) begin
            pend_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            best_reg       <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            best_reg       <= best_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take_last) begin
            pend_len_reg  <= best_max;
            pend_over_reg <= q_in.over;
        end
        if (done) begin
            out_len_reg  <= pend_len_reg;
            out_over_reg <= pend_over_reg;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = OUT_DATA_W'(out_len_reg);
    assign m_tuser[0] = out_over_reg;

endmodule
`default_nettype wire

@@ dv/lzsr_checker.sv @@
`timescale 1ns / 100ps
module lzsr_checker
    import lzsr_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    input  wire logic                  s_tready,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,   // value
    input  wire logic                  s_tlast,
    input  wire logic                  m_tvalid,
    input  wire logic                  m_tready,
    input  wire logic [OUT_DATA_W-1:0] m_tdata,   // length, zero padded
    input  wire logic [0:0]            m_tuser,   // too_long
    output int                         mismatches,
    output int                         awaited
);

    typedef struct {
        logic [LEN_W-1:0] length;
        logic             too_long;
    } run_result_t;

    run_result_t expected_runs[$];

    longint prefix_sum;
    int     elem_count;
    int     longest;
    bit     overflow_seen;
    longint sum_at    [0:MAX_LEN];
    bit     sum_known [0:MAX_LEN];

    function automatic void start_array();
        prefix_sum    = 0;
        elem_count    = 0;
        longest       = 0;
        overflow_seen = 1'b0;
        for (int i = 0; i <= MAX_LEN; i++) begin
            sum_known[i] = 1'b0;
        end
        sum_at[0]    = 0;
        sum_known[0] = 1'b1;
    endfunction

    // earliest position holding the same prefix sum bounds a zero-sum run
    function automatic void absorb_element(logic signed [VALUE_BITS-1:0] v);
        bit hit;
        hit = 1'b0;
        prefix_sum += v;
        elem_count++;
        for (int p = 0; p < elem_count && !hit; p++) begin
            if (sum_known[p] && sum_at[p] == prefix_sum) begin
                if (elem_count - p > longest) begin
                    longest = elem_count - p;
                end
                hit = 1'b1;
            end
        end
        if (!hit) begin
            sum_at[elem_count]    = prefix_sum;
            sum_known[elem_count] = 1'b1;
        end
    endfunction

    task automatic flag_result(input string msg);
        mismatches++;
        if (mismatches <= 10) begin
            $display("mismatch at %0t: %s", $realtime, msg);
        end
    endtask

    always @(posedge aclk) begin : watch
        run_result_t              want;
        logic [OUT_DATA_W-1:0]    want_data;
        if (!aresetn) begin
            start_array();
            expected_runs.delete();
            mismatches = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_runs.size() == 0) begin
                    flag_result($sformatf("unexpected transaction tdata=%0d tuser=%0b",
                                          m_tdata, m_tuser[0]));
                end else begin
                    want      = expected_runs.pop_front();
                    want_data = OUT_DATA_W'(want.length);
                    if (m_tdata !== want_data) begin
                        flag_result($sformatf("length expected %0d actual %0d",
                                              want_data, m_tdata));
                    end
                    if (m_tuser[0] !== want.too_long) begin
                        flag_result($sformatf("too_long expected %0b actual %0b",
                                              want.too_long, m_tuser[0]));
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                if (elem_count < MAX_LEN) begin
                    absorb_element($signed(s_tdata[VALUE_BITS-1:0]));
                end else begin
                    overflow_seen = 1'b1;
                end
                if (s_tlast) begin
                    want.length   = LEN_W'(longest);
                    want.too_long = overflow_seen;
                    expected_runs.push_back(want);
                    start_array();
                end
            end
        end
        awaited = expected_runs.size();
    end

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 100ps
module tb;
    import lzsr_pkg::*;

    typedef enum {
        VAL_SMALL,
        VAL_FULL,
        VAL_EDGE,
        VAL_ZERO
    } value_mix_t;

    logic                  aclk;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic                  s_tlast  = 1'b0;
    logic                  m_tready = 1'b0;
    wire logic             s_tready;
    wire logic             m_tvalid;
    wire logic [OUT_DATA_W-1:0] m_tdata;
    wire logic [0:0]       m_tuser;

    int src_idle_pct  = 0;
    int sink_idle_pct = 0;
    int sink_hold     = 0;
    int mismatches;
    int awaited;

    longest_zero_sum_run i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    lzsr_checker i_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .mismatches (mismatches),
        .awaited    (awaited)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #10_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // receiver side, with a long hold-off when requested
    always @(negedge aclk) begin
        if (sink_hold > 0) begin
            m_tready = 1'b0;
            sink_hold--;
        end else begin
            m_tready = ($urandom_range(99) >= sink_idle_pct);
        end
    end

    task automatic set_idle(input int src_pct, input int sink_pct);
        @(posedge aclk);
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        @(negedge aclk);
    endtask

    // called at a falling edge; returns at the falling edge after the transaction
    task automatic send_element(input logic [IN_DATA_W-1:0] v, input logic last);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = v;
        s_tlast  = last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    function automatic logic [IN_DATA_W-1:0] pick_value(input value_mix_t mix);
        case (mix)
            VAL_SMALL: return IN_DATA_W'(int'($urandom_range(6)) - 3);
            VAL_FULL:  return IN_DATA_W'($urandom);
            VAL_EDGE: begin
                case ($urandom_range(4))
                    0:       return 16'h8000;
                    1:       return 16'h7FFF;
                    2:       return 16'h0000;
                    3:       return 16'hFFFF;
                    default: return 16'h0001;
                endcase
            end
            default:   return '0;
        endcase
    endfunction

    task automatic send_array(input int n, input value_mix_t mix);
        for (int i = 0; i < n; i++) begin
            send_element(pick_value(mix), i == n - 1);
        end
    endtask

    task automatic random_arrays(input int items);
        int         sent;
        int         len;
        int         roll;
        value_mix_t mix;
        sent = 0;
        while (sent < items) begin
            roll = $urandom_range(99);
            if (roll < 80) len = $urandom_range(8, 1);
            else if (roll < 95) len = $urandom_range(40, 9);
            else len = $urandom_range(120, 41);
            roll = $urandom_range(99);
            if (roll < 50) mix = VAL_SMALL;
            else if (roll < 80) mix = VAL_FULL;
            else mix = VAL_EDGE;
            send_array(len, mix);
            sent += len;
        end
    endtask

    task automatic wait_drained();
        s_tvalid = 1'b0;
        wait (awaited == 0);
        @(negedge aclk);
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        set_idle(15, 47);
        send_element(16'h0000, 1'b1);
        send_element(16'h0005, 1'b1);
        send_element(16'h7FFF, 1'b0);
        send_element(16'h8000, 1'b0);
        send_element(16'h0001, 1'b1);
        send_element(16'h8000, 1'b0);
        send_element(16'h7FFF, 1'b0);
        send_element(16'h0001, 1'b1);
        send_element(16'h0003, 1'b0);
        send_element(16'hFFFD, 1'b1);
        send_element(16'h0005, 1'b0);
        send_element(16'h0001, 1'b0);
        send_element(16'hFFFF, 1'b0);
        send_element(16'h0002, 1'b0);
        send_element(16'hFFFE, 1'b1);
        send_element(16'h0001, 1'b0);
        send_element(16'h0001, 1'b0);
        send_element(16'h0001, 1'b1);
        send_element(16'hFFFF, 1'b0);
        send_element(16'h0001, 1'b1);
        // full length with the longest possible run, then an overlong array
        send_array(MAX_LEN, VAL_ZERO);
        send_array(MAX_LEN + 6, VAL_SMALL);
        random_arrays(330);
        wait_drained();

        set_idle(47, 15);
        @(posedge aclk);
        sink_hold = 6000;
        @(negedge aclk);
        for (int i = 0; i < 6; i++) begin
            send_array(3, VAL_SMALL);
        end
        random_arrays(330);
        wait_drained();

        set_idle(0, 0);
        random_arrays(340);
        wait_drained();

        repeat (2 * MAX_LEN + 16) @(posedge aclk);
        if (mismatches == 0 && awaited == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
